// ----- rtl/core/csvt_pkg.sv -----
// Shared types and constants for the CSV quoted field tokenizer.
// Used by the step logic, the top level and the port checker. No dependencies.
package csvt_pkg;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_QUOTE = 8'd34;

  localparam logic [7:0] DELIMITER_RESET  = 8'd44;
  localparam logic       ALLOW_UTF8_RESET = 1'b0;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DELIMITER  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_UTF8 = 1'd1;
  localparam int unsigned CFG_DATA_W = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } csvt_in_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_out;
    logic       field_end;
    logic       row_end;
    logic       input_done;
  } csvt_out_t;

  typedef struct packed {
    logic       held_valid;
    logic [7:0] held_char;
    logic       field_released;
    logic       in_quotes;
    logic       quote_run_parity;
    logic       prev_was_quote;
    logic       row_has_fields;
  } csvt_state_t;

endpackage

// ----- rtl/core/csvt_step.sv -----
// Combinational step of the tokenizer: one byte against the current state.
// Depends on csvt_pkg for the item, result and state types.
module csvt_step (
  input  csvt_pkg::csvt_state_t state,
  input  csvt_pkg::csvt_in_t    item,
  input  logic [7:0]            delimiter,
  input  logic                  allow_utf8,
  output csvt_pkg::csvt_state_t state_nxt,
  output csvt_pkg::csvt_out_t   res,
  output logic                  res_valid
);

  always_comb begin
    logic       eof;
    logic       field_empty;
    logic       lead;
    logic       is_quote;
    logic       field_done;
    logic       row_done;
    logic       hv;
    logic [7:0] c;
    csvt_pkg::csvt_state_t s;

    eof         = item.end_of_input;
    field_empty = !state.held_valid && !state.field_released;
    s           = state;
    res         = '0;
    res_valid   = 1'b0;
    c           = eof ? csvt_pkg::CH_LF : item.data_byte;
    lead        = field_empty && !state.prev_was_quote;
    is_quote    = (c == csvt_pkg::CH_QUOTE);
    field_done  = 1'b0;
    row_done    = 1'b0;
    hv          = 1'b0;

    if (eof && field_empty && !state.row_has_fields) begin
      // Nothing pending: report completion only.
      res.input_done = 1'b1;
      res_valid      = 1'b1;
    end else if (!eof && ((c[7] && !allow_utf8) || c == csvt_pkg::CH_CR)) begin
      // Dropped byte: state and output stay as they are.
    end else if (lead && is_quote) begin
      s.in_quotes      = 1'b1;
      s.prev_was_quote = 1'b1;
    end else begin
      if (!lead && is_quote) begin
        s.quote_run_parity = !state.quote_run_parity;
        s.in_quotes        = state.quote_run_parity;
        if (state.quote_run_parity) begin
          s.held_valid = 1'b0;   // a doubled quote cancels the first one
        end
      end else if (!lead) begin
        s.quote_run_parity = 1'b0;
      end

      field_done = eof || ((c == delimiter || c == csvt_pkg::CH_LF) && !s.in_quotes);
      row_done   = (c == csvt_pkg::CH_LF);

      if (field_done) begin
        hv             = s.held_valid && !state.prev_was_quote;   // trim trailing quote
        res.char_valid = hv;
        res.char_out   = hv ? s.held_char : 8'd0;
        res.field_end  = 1'b1;
        res.row_end    = row_done;
        res_valid      = 1'b1;
        s.held_valid     = 1'b0;
        s.held_char      = 8'd0;
        s.field_released = 1'b0;
        s.in_quotes      = 1'b0;
        if (row_done) begin
          s.quote_run_parity = 1'b0;
          s.prev_was_quote   = 1'b0;
          s.row_has_fields   = 1'b0;
        end else begin
          s.row_has_fields = 1'b1;
          s.prev_was_quote = is_quote;
        end
      end else begin
        if (s.held_valid) begin
          res.char_valid   = 1'b1;
          res.char_out     = s.held_char;
          res_valid        = 1'b1;
          s.field_released = 1'b1;
        end
        s.held_char      = c;
        s.held_valid     = 1'b1;
        s.prev_was_quote = is_quote;
      end
    end

    state_nxt = s;
  end

endmodule

// ----- rtl/core/csv_quoted_field_tokenizer.sv -----
// Top level of the CSV quoted field tokenizer: input register, step logic,
// state and configuration registers, result register. Uses csvt_pkg, csvt_step.
//
// The input channel (in_valid, in_stall, in_data) carries one transaction per
// CSV byte, or an end-of-input mark when in_data.end_of_input is set. The result
// channel (out_valid, out_stall, out_data) carries field characters with field-end
// and row-end marks, or a done mark at end of input when no field or row is open.
// Carriage returns, dropped non-ASCII bytes and a leading quote produce nothing.
// The last character seen is held back until the next kept byte, so that a
// later quote can still cancel it.
// Timing: an accepted transaction is registered in the input register and is
// processed from there when it can advance; its result is then loaded into the
// result register, from which the receiver takes it. The state update is one
// combinational pass over the state, so one transaction is accepted every cycle
// while in_stall is low. Stall: while out_stall holds a result, a transaction
// that causes no result still advances; otherwise it waits in the input
// register and in_stall rises. Reset: rst_n is synchronous and active low. It
// empties both registers, clears the tokenizer state, and sets the delimiter to
// comma and allow_utf8 to 0. Configuration: cfg_we with cfg_index and cfg_wdata
// writes a register. Writes are expected only while the block is idle.
module csv_quoted_field_tokenizer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  csvt_pkg::csvt_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output csvt_pkg::csvt_out_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [csvt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [csvt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // Input register.
  logic                  in_vld_r;
  logic                  in_vld_nxt;
  csvt_pkg::csvt_in_t    in_item_r;

  // Tokenizer state and configuration.
  csvt_pkg::csvt_state_t state_r;
  csvt_pkg::csvt_state_t state_nxt;
  logic [7:0]            delimiter_r;
  logic                  allow_utf8_r;

  // Result register.
  logic                  out_vld_r;
  logic                  out_vld_nxt;
  csvt_pkg::csvt_out_t   out_data_r;

  csvt_pkg::csvt_out_t   step_res;
  logic                  step_res_valid;
  logic                  advance;
  logic                  in_accept;

  csvt_step u_step (
    .state      (state_r),
    .item       (in_item_r),
    .delimiter  (delimiter_r),
    .allow_utf8 (allow_utf8_r),
    .state_nxt  (state_nxt),
    .res        (step_res),
    .res_valid  (step_res_valid)
  );

  // The held transaction may be processed when it produces no result or the
  // result register is free or being emptied this cycle.
  assign advance   = in_vld_r && (!step_res_valid || !out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance && step_res_valid) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r <= in_data;
    end
    if (advance && step_res_valid) begin
      out_data_r <= step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delimiter_r  <= csvt_pkg::DELIMITER_RESET;
      allow_utf8_r <= csvt_pkg::ALLOW_UTF8_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        csvt_pkg::REG_DELIMITER: begin
          delimiter_r <= cfg_wdata[7:0];
        end
        csvt_pkg::REG_ALLOW_UTF8: begin
          allow_utf8_r <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/csvt_checker.sv -----
// Port-level checker for the CSV quoted field tokenizer, with its bind.
// Depends on csvt_pkg and the top level csv_quoted_field_tokenizer.
module csvt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input csvt_pkg::csvt_out_t             out_data
);

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A done mark carries nothing else.
  a_done_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.input_done |->
      !out_data.char_valid && !out_data.field_end && !out_data.row_end)
    else $error("done mark mixed with field output");

  // A row ends only together with its last field.
  a_row_has_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.row_end |-> out_data.field_end)
    else $error("row end without field end");

  // Without a character, the character byte reads as zero.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.char_valid |-> out_data.char_out == 8'd0)
    else $error("char_out nonzero without char_valid");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind csv_quoted_field_tokenizer csvt_checker u_csvt_checker (.*);

// ----- sim/tb_csv_quoted_field_tokenizer.sv -----
// Self-checking testbench for the CSV quoted field tokenizer: directed and random
// byte streams under several delimiter and UTF-8 settings, with sender and receiver
// idling. Depends on csvt_pkg and csv_quoted_field_tokenizer.
module tb_csv_quoted_field_tokenizer;

  // Cycles that an accepted transaction may still spend inside the block after
  // the last expected result has come out (input register plus result register).
  localparam int unsigned PIPE_SETTLE = 6;
  // Run limit.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Only the first mismatches are printed; the rest are counted.
  localparam int unsigned MAX_PRINTED = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  csvt_pkg::csvt_in_t   in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  csvt_pkg::csvt_out_t  out_data;
  logic                 cfg_we;
  logic [csvt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [csvt_pkg::CFG_DATA_W-1:0] cfg_wdata;

  csv_quoted_field_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Tokens that the block still owes us, oldest first.
  csvt_pkg::csvt_out_t expected_tokens[$];

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  // Idling in percent: send_idle_pct for the sender, stall_pct for the receiver.
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  // A long receiver hold-off is requested by bumping hold_req; the receiver
  // acknowledges it and counts the stretch down itself.
  int unsigned hold_req = 0;
  int unsigned hold_len = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;

  // Our own copy of the configuration registers.
  logic [7:0] cur_delim;
  logic       cur_utf8;

  // Our own copy of the tokenizer state.
  logic       tk_held_valid;
  logic [7:0] tk_held_char;
  logic       tk_released;
  logic       tk_in_quotes;
  logic       tk_quote_parity;
  logic       tk_prev_quote;
  logic       tk_row_open;

  // Clock with a period of 10 time units.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and watchdog. A hung handshake or a missing result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_csv_quoted_field_tokenizer: done, errors");
      $finish;
    end
  end

  // Receiver: stalls at random at the chosen rate. A requested hold-off takes
  // precedence and keeps the stall high for the whole stretch, which lets the
  // block fill up and push back on the sender.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_stall <= 1'b1;
      hold_left = hold_len - 1;
      hold_ack = hold_req;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Prints one line per mismatch (up to a cap) and counts every one.
  task automatic report_error(string msg);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("tb_csv_quoted_field_tokenizer: cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_error($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Result checker. Sampled at the rising edge, so the values seen are the ones
  // the block presented during the cycle that completed the transaction.
  always @(posedge clk) begin
    csvt_pkg::csvt_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        report_error($sformatf("result %h arrived with nothing expected", out_data));
      end else begin
        want = expected_tokens.pop_front();
        check_field("char_valid", out_data.char_valid, want.char_valid);
        check_field("char_out",   out_data.char_out,   want.char_out);
        check_field("field_end",  out_data.field_end,  want.field_end);
        check_field("row_end",    out_data.row_end,    want.row_end);
        check_field("input_done", out_data.input_done, want.input_done);
      end
    end
  end

  task automatic clear_tokenizer();
    tk_held_valid   = 1'b0;
    tk_held_char    = 8'd0;
    tk_released     = 1'b0;
    tk_in_quotes    = 1'b0;
    tk_quote_parity = 1'b0;
    tk_prev_quote   = 1'b0;
    tk_row_open     = 1'b0;
  endtask

  // Advances our tokenizer by one accepted byte or end-of-input mark. Returns 1
  // and fills tok when the step releases a token.
  function automatic bit tokenize_step(input csvt_pkg::csvt_in_t item,
                                       output csvt_pkg::csvt_out_t tok);
    logic       eoi;
    logic [7:0] c;
    logic       field_empty;
    logic       row_done;
    bit         released;
    tok = '0;
    eoi = item.end_of_input;
    field_empty = !tk_held_valid && !tk_released;
    if (eoi) begin
      // With nothing open, end of input only reports that the text is done.
      if (field_empty && !tk_row_open) begin
        tok.input_done = 1'b1;
        return 1'b1;
      end
      // Otherwise it closes the open row like a newline would.
      c = csvt_pkg::CH_LF;
    end else begin
      c = item.data_byte;
      // Dropped bytes leave the state untouched.
      if (c[7] && !cur_utf8)
        return 1'b0;
      if (c == csvt_pkg::CH_CR)
        return 1'b0;
    end

    if (field_empty && !tk_prev_quote) begin
      // A quote at the very start of a field opens a quoted field and is not content.
      if (c == csvt_pkg::CH_QUOTE) begin
        tk_in_quotes  = 1'b1;
        tk_prev_quote = 1'b1;
        return 1'b0;
      end
    end else if (c == csvt_pkg::CH_QUOTE) begin
      tk_quote_parity = !tk_quote_parity;
      tk_in_quotes    = !tk_quote_parity;
      // The second quote of a pair cancels the first one still held back.
      if (tk_in_quotes)
        tk_held_valid = 1'b0;
    end else begin
      tk_quote_parity = 1'b0;
    end

    if (eoi || ((c == cur_delim || c == csvt_pkg::CH_LF) && !tk_in_quotes)) begin
      row_done = (c == csvt_pkg::CH_LF);
      // A quote that closes the field is trimmed.
      if (tk_prev_quote)
        tk_held_valid = 1'b0;
      tok.char_valid = tk_held_valid;
      tok.char_out   = tk_held_valid ? tk_held_char : 8'd0;
      tok.field_end  = 1'b1;
      tok.row_end    = row_done;
      tk_held_valid  = 1'b0;
      tk_held_char   = 8'd0;
      tk_released    = 1'b0;
      tk_in_quotes   = 1'b0;
      if (row_done) begin
        tk_quote_parity = 1'b0;
        tk_prev_quote   = 1'b0;
        tk_row_open     = 1'b0;
      end else begin
        tk_row_open   = 1'b1;
        tk_prev_quote = (c == csvt_pkg::CH_QUOTE);
      end
      return 1'b1;
    end

    // Ordinary character: release the held one, hold the new one.
    released = tk_held_valid;
    if (tk_held_valid) begin
      tok.char_valid = 1'b1;
      tok.char_out   = tk_held_char;
      tk_released    = 1'b1;
    end
    tk_held_char  = c;
    tk_held_valid = 1'b1;
    tk_prev_quote = (c == csvt_pkg::CH_QUOTE);
    return released;
  endfunction

  // Offers one transaction and returns at the falling edge after it was taken.
  // in_valid is left high; the next call or stop_sending decides what follows.
  task automatic send_item(csvt_pkg::csvt_in_t item);
    csvt_pkg::csvt_out_t tok;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    forever begin
      @(posedge clk);
      if (!in_stall)
        break;
    end
    if (tokenize_step(item, tok))
      expected_tokens = {expected_tokens, tok};
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    csvt_pkg::csvt_in_t item;
    item.data_byte    = b;
    item.end_of_input = 1'b0;
    send_item(item);
  endtask

  // End-of-input mark; the data byte is random since the block must ignore it.
  task automatic send_eoi();
    csvt_pkg::csvt_in_t item;
    item.data_byte    = 8'($urandom_range(0, 255));
    item.end_of_input = 1'b1;
    send_item(item);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i]);
  endtask

  // Lowers in_valid at the current falling edge.
  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // The sender pauses until every expected token has come out, then waits for
  // transactions that cause no token to leave the pipeline.
  task automatic drain();
    stop_sending();
    while (expected_tokens.size() != 0)
      @(negedge clk);
    repeat (PIPE_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [csvt_pkg::CFG_IDX_W-1:0] idx,
                           logic [csvt_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Registers change only while the block is idle.
  task automatic set_config(logic [7:0] delim, logic utf8);
    drain();
    write_reg(csvt_pkg::REG_DELIMITER, delim);
    write_reg(csvt_pkg::REG_ALLOW_UTF8, csvt_pkg::CFG_DATA_W'(utf8));
    cur_delim = delim;
    cur_utf8  = utf8;
  endtask

  // Random CSV-like traffic. Most bytes are plain text, delimiters and quotes so
  // that quoted fields, doubled quotes and trailing quotes occur often; the rest
  // is newlines, CRs, high, control and full-range bytes and end-of-input marks.
  task automatic send_random(int unsigned count);
    int unsigned r;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 38)
        send_byte(8'($urandom_range(32, 126)));
      else if (r < 52)
        send_byte(cur_delim);
      else if (r < 66)
        send_byte(csvt_pkg::CH_QUOTE);
      else if (r < 74)
        send_byte(csvt_pkg::CH_LF);
      else if (r < 78)
        send_byte(csvt_pkg::CH_CR);
      else if (r < 84)
        send_byte(8'($urandom_range(128, 255)));
      else if (r < 93)
        send_byte(8'($urandom_range(0, 255)));
      else if (r < 96)
        send_eoi();
      else
        send_byte(8'($urandom_range(0, 31)));
    end
  endtask

  // Reset settings: empty input, a leading quote alone, quoted and doubled
  // quotes, a trailing quote, empty fields and dropped bytes.
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    send_eoi();
    send_byte(csvt_pkg::CH_QUOTE);
    send_eoi();
    send_text("a,\"b\"\"c\",d");
    send_byte(csvt_pkg::CH_CR);
    send_byte(csvt_pkg::CH_LF);
    send_text("x\"");
    send_byte(csvt_pkg::CH_LF);
    send_text(",,");
    send_eoi();
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(csvt_pkg::CH_LF);
  endtask

  // High bytes become field content once UTF-8 is allowed.
  task automatic test_utf8_bytes();
    set_config(8'd44, 1'b1);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'hC3);
    send_byte(csvt_pkg::CH_LF);
    send_byte(csvt_pkg::CH_QUOTE);
    send_byte(8'hA9);
    send_byte(csvt_pkg::CH_QUOTE);
    send_eoi();
  endtask

  // Delimiters that collide with quote, newline or carriage return, plus the
  // values 1 and 255, the latter the top of the register range.
  task automatic test_unusual_delimiters();
    logic [7:0] delims[5];
    delims = '{csvt_pkg::CH_QUOTE, csvt_pkg::CH_LF, csvt_pkg::CH_CR, 8'd1, 8'd255};
    send_idle_pct = 10;
    stall_pct = 10;
    foreach (delims[i]) begin
      set_config(delims[i], 1'(i % 2));
      send_text("p\"q\"");
      send_byte(delims[i]);
      send_random(30);
    end
  endtask

  // Long random runs under each idling pattern, each with its own configuration.
  task automatic test_random_traffic();
    set_config(8'd44, 1'b0);
    send_idle_pct = 0;
    stall_pct = 0;
    send_random(270);

    set_config(8'd9, 1'b1);
    send_idle_pct = 85;
    stall_pct = 0;
    send_random(270);

    set_config(8'd255, 1'b1);
    send_idle_pct = 0;
    stall_pct = 85;
    send_random(270);

    set_config(8'd59, 1'b0);
    send_idle_pct = 28;
    stall_pct = 28;
    send_random(270);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // transactions back to back, so the block fills and raises in_stall.
  task automatic test_backpressure();
    set_config(8'd44, 1'b1);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_len = 200;
    hold_req = hold_req + 1;
    send_random(100);
  endtask

  initial begin
    send_idle_pct = 0;
    stall_pct     = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cur_delim = csvt_pkg::DELIMITER_RESET;
    cur_utf8  = csvt_pkg::ALLOW_UTF8_RESET;
    clear_tokenizer();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_utf8_bytes();
    test_unusual_delimiters();
    test_random_traffic();
    test_backpressure();

    stall_pct = 0;
    drain();
    if (error_count == 0)
      $display("tb_csv_quoted_field_tokenizer: done, clean");
    else
      $display("tb_csv_quoted_field_tokenizer: done, errors");
    $finish;
  end

endmodule

// ----- csv_quoted_field_tokenizer.f -----
rtl/core/csvt_pkg.sv
rtl/core/csvt_step.sv
rtl/core/csv_quoted_field_tokenizer.sv
rtl/core/csvt_checker.sv
sim/tb_csv_quoted_field_tokenizer.sv
